// ----- rtl/lppr_pkg.sv -----
// lppr_pkg: shared widths, field layout and action codes for the packet reassembler
// no dependencies
package lppr_pkg;

  localparam int CLIENTS_DEF      = 16;
  localparam int PACKET_BYTES_DEF = 64;

  localparam int CLIENT_W = 4;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;

  // s_tdata: client, data_byte
  localparam int S_TDATA_W = 16;
  // m_tdata: out_client, out_byte, byte_index
  localparam int M_TDATA_W = 24;

  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_RESET = 1'b1;

endpackage

// ----- rtl/length_prefixed_packet_reassembler_core.sv -----
// length_prefixed_packet_reassembler_core: per-client packet reassembly top level
// depends on lppr_pkg and lppr_ram
//
// usage: the slave stream carries one transfer per byte or client reset
// (s_tuser = action, s_tdata = client, data_byte). each client keeps its
// expected length and byte count in a small state ram and its bytes in a
// packet ram. a transfer reads the client state in S_IDLE, then updates it
// and writes the byte in S_LOOK. when a packet completes, the master
// stream delivers its bytes in order, one per cycle while m_tready is high,
// m_tlast on the final byte; s_tready stays low until the last packet byte
// has been read from the packet ram. a bad length byte gives one transfer
// with m_tuser and m_tlast set. the output stage is a register: a stall on
// m_tready holds the current transfer and pauses the packet ram reads.
// rst clears all client state at once through per-client valid bits;
// no clearing pass is needed and s_tready rises as soon as rst is released.
module length_prefixed_packet_reassembler_core
  import lppr_pkg::*;
#(
  parameter int CLIENTS      = CLIENTS_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // client[3:0], data_byte[11:4], zero pad
  input  logic [0:0]           s_tuser,  // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,  // out_client[3:0], out_byte[11:4], byte_index[17:12]
  output logic                 m_tlast,
  output logic [0:0]           m_tuser   // bad_length
);

  localparam int CW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int OW  = $clog2(PACKET_BYTES);
  localparam int LW  = $clog2(PACKET_BYTES + 1);
  localparam int AW  = CW + OW;
  localparam int STW = 2 * LW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]          state, state_next;
  logic                act_q;
  logic [CW-1:0]       cidx_q;
  logic [BYTE_W-1:0]   byte_q;
  logic                vld_q;
  logic [CLIENTS-1:0]  vld;

  logic [CW-1:0]       dcl;
  logic [LW-1:0]       dn;
  logic [LW-1:0]       rd_off;
  logic                dbad;

  logic                ov;
  logic [CLIENT_W-1:0] o_client;
  logic [INDEX_W-1:0]  o_idx;
  logic                o_last;
  logic                o_bad;

  logic [CLIENT_W-1:0] in_client;
  logic [BYTE_W-1:0]   in_byte;
  logic                in_range;
  logic                acc;

  logic                st_re;
  logic                st_we;
  logic [STW-1:0]      st_wdata;
  logic [STW-1:0]      st_rdata;
  logic [LW-1:0]       elen;
  logic [LW-1:0]       held;

  logic                pk_we;
  logic [OW-1:0]       pk_woff;
  logic                pk_re;
  logic [BYTE_W-1:0]   pk_rdata;

  logic                start;
  logic [LW-1:0]       start_n;
  logic                start_bad;
  logic                adv;

  assign in_client = s_tdata[CLIENT_W-1:0];
  assign in_byte   = s_tdata[CLIENT_W +: BYTE_W];
  assign in_range  = 32'(in_client) < CLIENTS;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign acc       = s_tvalid && s_tready;
  assign st_re     = acc && in_range;

  assign elen = vld_q ? st_rdata[STW-1:LW] : '0;
  assign held = vld_q ? st_rdata[LW-1:0]   : '0;

  assign adv   = !ov || m_tready;
  assign pk_re = (state == S_DRAIN) && adv;

  always_comb begin
    st_we      = 1'b0;
    st_wdata   = '0;
    pk_we      = 1'b0;
    pk_woff    = '0;
    start      = 1'b0;
    start_n    = '0;
    start_bad  = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (st_re) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        st_we      = 1'b1;
        state_next = S_IDLE;
        if (act_q == ACT_DATA) begin
          if (elen == '0) begin
            pk_we = 1'b1;
            if (byte_q == '0 || 32'(byte_q) > PACKET_BYTES) begin
              start     = 1'b1;
              start_n   = LW'(1);
              start_bad = 1'b1;
            end else if (byte_q == BYTE_W'(1)) begin
              start   = 1'b1;
              start_n = LW'(1);
            end else begin
              st_wdata = {LW'(byte_q), LW'(1)};
            end
          end else if (held < elen) begin
            pk_we   = 1'b1;
            pk_woff = OW'(held);
            if (held + LW'(1) == elen) begin
              start   = 1'b1;
              start_n = elen;
            end else begin
              st_wdata = {elen, held + LW'(1)};
            end
          end
        end
        if (start) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (adv && rd_off + LW'(1) == dn) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vld   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (st_we) begin
        vld[cidx_q] <= 1'b1;
      end
      if (pk_re) begin
        ov <= 1'b1;
      end else if (m_tready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      act_q  <= s_tuser[0];
      cidx_q <= CW'(in_client);
      byte_q <= in_byte;
      vld_q  <= vld[CW'(in_client)];
    end
    if (start) begin
      dcl    <= cidx_q;
      dn     <= start_n;
      rd_off <= '0;
      dbad   <= start_bad;
    end else if (pk_re) begin
      rd_off <= rd_off + LW'(1);
    end
    if (pk_re) begin
      o_client <= CLIENT_W'(dcl);
      o_idx    <= INDEX_W'(rd_off);
      o_last   <= (rd_off + LW'(1) == dn);
      o_bad    <= dbad;
    end
  end

  lppr_ram #(
    .WIDTH(STW),
    .DEPTH(CLIENTS)
  ) u_state_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(cidx_q),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(CW'(in_client)),
    .rdata(st_rdata)
  );

  lppr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(2 ** AW)
  ) u_packet_ram (
    .clk  (clk),
    .we   (pk_we),
    .waddr({cidx_q, pk_woff}),
    .wdata(byte_q),
    .re   (pk_re),
    .raddr({dcl, OW'(rd_off)}),
    .rdata(pk_rdata)
  );

  assign m_tvalid   = ov;
  assign m_tdata    = M_TDATA_W'({o_idx, pk_rdata, o_client});
  assign m_tlast    = o_last;
  assign m_tuser[0] = o_bad;

endmodule

// ----- rtl/lppr_ram.sv -----
// lppr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module lppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lppr_checker.sv -----
// lppr_checker: port-level assertions for the packet reassembler, bound to the top level
// depends on lppr_pkg and length_prefixed_packet_reassembler_core
module lppr_checker
  import lppr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [0:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast,
  input logic [0:0]           m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("master transfer changed under stall");

  // error result is a single transfer at index zero
  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[17:12] == 6'd0)
    else $error("bad length result not single");

  // packet of length one ends on its length byte
  a_len1: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && m_tdata[17:12] == 6'd0 && m_tdata[11:4] == 8'd1 |-> m_tlast)
    else $error("length one packet not marked last");

  // no input taken while a packet is mid delivery
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted during packet delivery");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind length_prefixed_packet_reassembler_core lppr_checker u_lppr_checker (.*);
